[rtl/qpmc_pkg.sv]
// shared constants, codes and types of the quadrature encoder pid motor controller
// no dependencies; imported by every module of the block
package qpmc_pkg;

    localparam int COUNT_W    = 32;
    localparam int SPEED_W    = 16;
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 15;
    localparam int DRIVE_W    = 9;
    localparam int DUTY_W     = 8;
    localparam int INT_OUT_W  = 11;
    localparam int DELTA_W    = 33;
    localparam int ACC_W      = 51;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // gains are in thousandths
    localparam int GAIN_SCALE = 1000;

    // exact floor(x / 1000) for x below 2^18 as (x * RECIP) >> RECIP_SHIFT
    localparam int DIV_IN_W    = 18;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE);

    localparam int unsigned INTEGRAL_LIMIT_DEF = 1000;
    localparam int unsigned DRIVE_LIMIT_DEF    = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_LOOP_MODE  = 3'd3,
        CFG_RUN_ENABLE = 3'd4,
        CFG_SETPOINT   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_PIN_CHANGE = 1'b0,
        CMD_TICK       = 1'b1
    } command_t;

    typedef enum logic {
        MODE_SPEED    = 1'b0,
        MODE_POSITION = 1'b1
    } loop_mode_t;

    // what the drive pipeline needs to know about an item
    typedef struct packed {
        logic tick;
        logic run;
    } item_ctl_t;

endpackage

[rtl/quadrature_pid_motor_controller_unit.sv]
// Quadrature encoder PID motor controller.
//
// Channels: the s_ channel carries one item per transfer: s_command low is an encoder
// pin change with the levels on s_chan_a and s_chan_b, s_command high is a control tick.
// Every item gives exactly one result on the m_ channel: the drive held since the last
// tick (signed, duty, reverse, pwm_on), the position count, and the speed, error and
// error sum of the last tick. Registers are written over the cfg_ channel, which is
// always ready; write them only while no item is in flight.
// Path: a result passes from its input transfer through the state register, the gain
// product register, the sum register and the division stage into the result register.
// Throughput: one item every cycle while results are taken, in any mix of pin changes
// and ticks; the loop state for the next tick is complete in the cycle after a tick.
// Reset: counts, loop state and drive are zero, gains are 1, speed mode, loop disabled,
// setpoint 0, nothing in flight.
// Stall: with m_ready low the pipeline keeps taking items until its five registers all
// hold items, then s_ready drops; no result is lost or repeated.
// Depends on qpmc_pkg, qpmc_state and qpmc_drive.
module quadrature_pid_motor_controller_unit import qpmc_pkg::*; #(
    parameter int unsigned INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int unsigned DRIVE_LIMIT    = DRIVE_LIMIT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic                        s_chan_a,
    input  logic                        s_chan_b,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DRIVE_W-1:0]   m_drive_signed,
    output logic [DUTY_W-1:0]           m_duty,
    output logic                        m_reverse,
    output logic                        m_pwm_on,
    output logic signed [COUNT_W-1:0]   m_count_now,
    output logic signed [SPEED_W-1:0]   m_speed_now,
    output logic signed [ERR_W-1:0]     m_err_now,
    output logic signed [INT_OUT_W-1:0] m_integral_now
);

    localparam int SUM_W = $clog2(INTEGRAL_LIMIT + 1) + 1;

    logic [GAIN_W-1:0]       prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    loop_mode_t              loop_mode_reg;
    logic                    run_enable_reg;
    logic signed [ERR_W-1:0] setpoint_reg;

    logic                      p1_valid, p1_ready;
    item_ctl_t                 p1_ctl;
    logic signed [COUNT_W-1:0] p1_count;
    logic signed [SPEED_W-1:0] p1_speed;
    logic signed [ERR_W-1:0]   p1_err;
    logic signed [SUM_W-1:0]   p1_sum;
    logic signed [DELTA_W-1:0] p1_delta;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= GAIN_W'(1);
            integ_gain_reg <= GAIN_W'(1);
            deriv_gain_reg <= GAIN_W'(1);
            loop_mode_reg  <= MODE_SPEED;
            run_enable_reg <= 1'b0;
            setpoint_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_LOOP_MODE:  loop_mode_reg  <= loop_mode_t'(cfg_data[0]);
                CFG_RUN_ENABLE: run_enable_reg <= cfg_data[0];
                CFG_SETPOINT:   setpoint_reg   <= signed'(cfg_data[ERR_W-1:0]);
                default: ;
            endcase
        end
    end

    qpmc_state #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .SUM_W          (SUM_W)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_chan_a   (s_chan_a),
        .s_chan_b   (s_chan_b),
        .loop_mode  (loop_mode_reg),
        .run_enable (run_enable_reg),
        .setpoint   (setpoint_reg),
        .p1_valid   (p1_valid),
        .p1_ready   (p1_ready),
        .p1_ctl     (p1_ctl),
        .p1_count   (p1_count),
        .p1_speed   (p1_speed),
        .p1_err     (p1_err),
        .p1_sum     (p1_sum),
        .p1_delta   (p1_delta)
    );

    qpmc_drive #(
        .DRIVE_LIMIT (DRIVE_LIMIT),
        .SUM_W       (SUM_W)
    ) u_drive (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (p1_valid),
        .in_ready       (p1_ready),
        .in_ctl         (p1_ctl),
        .in_count       (p1_count),
        .in_speed       (p1_speed),
        .in_err         (p1_err),
        .in_sum         (p1_sum),
        .in_delta       (p1_delta),
        .prop_gain      (prop_gain_reg),
        .integ_gain     (integ_gain_reg),
        .deriv_gain     (deriv_gain_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_signed (m_drive_signed),
        .m_duty         (m_duty),
        .m_reverse      (m_reverse),
        .m_pwm_on       (m_pwm_on),
        .m_count_now    (m_count_now),
        .m_speed_now    (m_speed_now),
        .m_err_now      (m_err_now),
        .m_integral_now (m_integral_now)
    );

    // input backpressure only once every stage holds an item and the result is stalled
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && p1_valid))
        else $error("input stalled while the pipeline has room");

    // the drive never leaves the configured limit
    a_drive_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty <= DUTY_W'(DRIVE_LIMIT)))
        else $error("drive magnitude beyond limit");

    // duty and sign describe the same drive value
    a_duty_matches_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_reverse ? (DRIVE_W'(0) - DRIVE_W'(m_drive_signed))
                                : DRIVE_W'(m_drive_signed)) == {1'b0, m_duty}))
        else $error("duty does not match signed drive");

    // nothing is presented right after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result presented right after reset");

endmodule

[rtl/qpmc_state.sv]
// encoder counter, loop state update and first pipeline register; one item per cycle if p1_ready
// depends on qpmc_pkg
module qpmc_state import qpmc_pkg::*; #(
    parameter int unsigned INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int          SUM_W          = $clog2(INTEGRAL_LIMIT + 1) + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic                      s_chan_a,
    input  logic                      s_chan_b,
    input  loop_mode_t                loop_mode,
    input  logic                      run_enable,
    input  logic signed [ERR_W-1:0]   setpoint,
    output logic                      p1_valid,
    input  logic                      p1_ready,
    output item_ctl_t                 p1_ctl,
    output logic signed [COUNT_W-1:0] p1_count,
    output logic signed [SPEED_W-1:0] p1_speed,
    output logic signed [ERR_W-1:0]   p1_err,
    output logic signed [SUM_W-1:0]   p1_sum,
    output logic signed [DELTA_W-1:0] p1_delta
);

    localparam logic signed [ERR_W:0] INT_HI = (ERR_W+1)'(INTEGRAL_LIMIT);
    localparam logic signed [ERR_W:0] INT_LO = -INT_HI;

    logic [COUNT_W-1:0]        pos_count_reg, pos_count_next;
    // position moved since the last tick, kept instead of the previous position
    logic [COUNT_W-1:0]        moved_reg, moved_next;
    logic                      prev_a_reg, prev_a_next;
    logic                      prev_b_reg, prev_b_next;
    logic signed [SPEED_W-1:0] prev_speed_reg, prev_speed_next;
    logic signed [SUM_W-1:0]   err_sum_reg, err_sum_next;
    logic signed [ERR_W-1:0]   err_hold_reg, err_hold_next;
    logic                      p1_valid_reg, p1_valid_next;

    item_ctl_t                 p1_ctl_reg;
    logic signed [COUNT_W-1:0] p1_count_reg;
    logic signed [SPEED_W-1:0] p1_speed_reg;
    logic signed [ERR_W-1:0]   p1_err_reg;
    logic signed [SUM_W-1:0]   p1_sum_reg;
    logic signed [DELTA_W-1:0] p1_delta_reg;

    logic                      accept;
    logic                      step_up, step_down;
    logic [COUNT_W-1:0]        count_step;
    logic signed [SPEED_W-1:0] speed_sat;
    logic signed [ERR_W:0]     target;
    logic signed [ERR_W:0]     err_full;
    logic signed [ERR_W-1:0]   err_sat;
    logic signed [ERR_W:0]     sum_full;
    logic signed [SUM_W-1:0]   sum_clamp;
    logic signed [DELTA_W-1:0] delta;

    assign s_ready = !p1_valid_reg || p1_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        step_up   = s_chan_a ^ prev_b_reg;
        step_down = s_chan_b ^ prev_a_reg;
        unique case ({step_up, step_down})
            2'b10:   count_step = COUNT_W'(1);
            2'b01:   count_step = '1;
            default: count_step = '0;
        endcase

        // velocity saturated to 16 bits
        if (moved_reg[COUNT_W-1:SPEED_W-1] == '0 || moved_reg[COUNT_W-1:SPEED_W-1] == '1) begin
            speed_sat = signed'(moved_reg[SPEED_W-1:0]);
        end else if (moved_reg[COUNT_W-1]) begin
            speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
        end

        if (loop_mode == MODE_SPEED) begin
            target = (ERR_W+1)'(speed_sat);
            delta  = DELTA_W'(prev_speed_reg) - DELTA_W'(speed_sat);
        end else begin
            target = (ERR_W+1)'(signed'(pos_count_reg));
            delta  = -DELTA_W'(signed'(moved_reg));
        end

        err_full = (ERR_W+1)'(setpoint) - target;
        if (err_full[ERR_W] == err_full[ERR_W-1]) begin
            err_sat = err_full[ERR_W-1:0];
        end else if (err_full[ERR_W]) begin
            err_sat = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            err_sat = {1'b0, {(ERR_W-1){1'b1}}};
        end

        sum_full = (ERR_W+1)'(err_sum_reg) + (ERR_W+1)'(err_sat);
        priority if (sum_full > INT_HI) begin
            sum_clamp = SUM_W'(INT_HI);
        end else if (sum_full < INT_LO) begin
            sum_clamp = SUM_W'(INT_LO);
        end else begin
            sum_clamp = SUM_W'(sum_full);
        end
    end

    always_comb begin
        pos_count_next  = pos_count_reg;
        moved_next      = moved_reg;
        prev_a_next     = prev_a_reg;
        prev_b_next     = prev_b_reg;
        prev_speed_next = prev_speed_reg;
        err_sum_next    = err_sum_reg;
        err_hold_next   = err_hold_reg;
        if (accept) begin
            if (command_t'(s_command) == CMD_PIN_CHANGE) begin
                pos_count_next = pos_count_reg + count_step;
                moved_next     = moved_reg + count_step;
                prev_a_next    = s_chan_a;
                prev_b_next    = s_chan_b;
            end else if (run_enable) begin
                moved_next      = '0;
                prev_speed_next = speed_sat;
                err_sum_next    = sum_clamp;
                err_hold_next   = err_sat;
            end else begin
                // disabled tick clears everything but the pin history
                pos_count_next  = '0;
                moved_next      = '0;
                prev_speed_next = '0;
                err_sum_next    = '0;
                err_hold_next   = '0;
            end
        end
        p1_valid_next = accept ? 1'b1 : (p1_ready ? 1'b0 : p1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_count_reg  <= '0;
            moved_reg      <= '0;
            prev_a_reg     <= 1'b0;
            prev_b_reg     <= 1'b0;
            prev_speed_reg <= '0;
            err_sum_reg    <= '0;
            err_hold_reg   <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            pos_count_reg  <= pos_count_next;
            moved_reg      <= moved_next;
            prev_a_reg     <= prev_a_next;
            prev_b_reg     <= prev_b_next;
            prev_speed_reg <= prev_speed_next;
            err_sum_reg    <= err_sum_next;
            err_hold_reg   <= err_hold_next;
            p1_valid_reg   <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ctl_reg.tick <= (command_t'(s_command) == CMD_TICK);
            p1_ctl_reg.run  <= run_enable;
            p1_count_reg    <= signed'(pos_count_next);
            p1_speed_reg    <= prev_speed_next;
            p1_err_reg      <= err_hold_next;
            p1_sum_reg      <= err_sum_next;
            p1_delta_reg    <= delta;
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1_ctl   = p1_ctl_reg;
    assign p1_count = p1_count_reg;
    assign p1_speed = p1_speed_reg;
    assign p1_err   = p1_err_reg;
    assign p1_sum   = p1_sum_reg;
    assign p1_delta = p1_delta_reg;

endmodule

[rtl/qpmc_drive.sv]
// pid drive pipeline: gain products, sum, divide by 1000, clamp, and the result register
// depends on qpmc_pkg
module qpmc_drive import qpmc_pkg::*; #(
    parameter int unsigned DRIVE_LIMIT = DRIVE_LIMIT_DEF,
    parameter int          SUM_W       = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  item_ctl_t                   in_ctl,
    input  logic signed [COUNT_W-1:0]   in_count,
    input  logic signed [SPEED_W-1:0]   in_speed,
    input  logic signed [ERR_W-1:0]     in_err,
    input  logic signed [SUM_W-1:0]     in_sum,
    input  logic signed [DELTA_W-1:0]   in_delta,
    input  logic [GAIN_W-1:0]           prop_gain,
    input  logic [GAIN_W-1:0]           integ_gain,
    input  logic [GAIN_W-1:0]           deriv_gain,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DRIVE_W-1:0]   m_drive_signed,
    output logic [DUTY_W-1:0]           m_duty,
    output logic                        m_reverse,
    output logic                        m_pwm_on,
    output logic signed [COUNT_W-1:0]   m_count_now,
    output logic signed [SPEED_W-1:0]   m_speed_now,
    output logic signed [ERR_W-1:0]     m_err_now,
    output logic signed [INT_OUT_W-1:0] m_integral_now
);

    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
    localparam int QUOT_W   = DIV_IN_W + RECIP_W;
    // smallest magnitude whose quotient exceeds the drive limit
    localparam logic [ACC_W-1:0] SAT_MAG = ACC_W'((DRIVE_LIMIT + 1) * GAIN_SCALE);

    typedef struct packed {
        item_ctl_t                 ctl;
        logic signed [COUNT_W-1:0] count;
        logic signed [SPEED_W-1:0] speed;
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   sum;
    } snap_t;

    logic v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next, m_valid_reg, m_valid_next;
    logic rdy2, rdy3, rdy4, rdy_out;

    snap_t                      snap2_reg, snap3_reg, snap4_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic                       over_reg;
    logic [DIV_IN_W-1:0]        mag_low_reg;
    logic signed [DRIVE_W-1:0]  drive_hold_reg, drive_hold_next;

    logic signed [DRIVE_W-1:0]   m_drive_reg;
    logic [DUTY_W-1:0]           m_duty_reg;
    logic signed [COUNT_W-1:0]   m_count_reg;
    logic signed [SPEED_W-1:0]   m_speed_reg;
    logic signed [ERR_W-1:0]     m_err_reg;
    logic signed [INT_OUT_W-1:0] m_sum_reg;

    logic [ACC_W-1:0]           mag;
    logic [QUOT_W-1:0]          quot_prod;
    logic [DUTY_W-1:0]          drive_mag;
    logic [DRIVE_W-1:0]         drive_calc;
    logic [DRIVE_W-1:0]         drive_neg;

    // a stage moves on when the one after it is empty or moving
    assign rdy_out  = !m_valid_reg || m_ready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_comb begin
        v2_next      = rdy2 ? in_valid : v2_reg;
        v3_next      = rdy3 ? v2_reg : v3_reg;
        v4_next      = rdy4 ? v3_reg : v4_reg;
        m_valid_next = rdy_out ? v4_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            drive_hold_reg <= '0;
        end else begin
            v2_reg         <= v2_next;
            v3_reg         <= v3_next;
            v4_reg         <= v4_next;
            m_valid_reg    <= m_valid_next;
            drive_hold_reg <= drive_hold_next;
        end
    end

    // gain products
    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            snap2_reg.ctl   <= in_ctl;
            snap2_reg.count <= in_count;
            snap2_reg.speed <= in_speed;
            snap2_reg.err   <= in_err;
            snap2_reg.sum   <= in_sum;
            prod_p_reg      <= signed'({1'b0, prop_gain}) * in_err;
            prod_i_reg      <= signed'({1'b0, integ_gain}) * in_sum;
            prod_d_reg      <= signed'({1'b0, deriv_gain}) * in_delta;
        end
    end

    // sum of the three terms
    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            snap3_reg <= snap2_reg;
            acc_reg   <= ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        end
    end

    // magnitude and saturation check, division works on the magnitude for truncation toward zero
    assign mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            snap4_reg   <= snap3_reg;
            neg_reg     <= acc_reg[ACC_W-1];
            over_reg    <= (mag >= SAT_MAG);
            mag_low_reg <= mag[DIV_IN_W-1:0];
        end
    end

    always_comb begin
        quot_prod  = QUOT_W'(mag_low_reg) * QUOT_W'(RECIP);
        drive_mag  = over_reg ? DUTY_W'(DRIVE_LIMIT) : quot_prod[RECIP_SHIFT +: DUTY_W];
        drive_calc = neg_reg ? DRIVE_W'(0) - {1'b0, drive_mag} : {1'b0, drive_mag};

        drive_hold_next = drive_hold_reg;
        if (rdy_out && v4_reg && snap4_reg.ctl.tick) begin
            drive_hold_next = snap4_reg.ctl.run ? signed'(drive_calc) : '0;
        end
        drive_neg = DRIVE_W'(0) - DRIVE_W'(drive_hold_next);
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v4_reg) begin
            m_drive_reg <= drive_hold_next;
            m_duty_reg  <= drive_hold_next[DRIVE_W-1] ? drive_neg[DUTY_W-1:0]
                                                      : drive_hold_next[DUTY_W-1:0];
            m_count_reg <= snap4_reg.count;
            m_speed_reg <= snap4_reg.speed;
            m_err_reg   <= snap4_reg.err;
            m_sum_reg   <= INT_OUT_W'(snap4_reg.sum);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_signed = m_drive_reg;
    assign m_duty         = m_duty_reg;
    assign m_reverse      = m_drive_reg[DRIVE_W-1];
    assign m_pwm_on       = (m_drive_reg != '0);
    assign m_count_now    = m_count_reg;
    assign m_speed_now    = m_speed_reg;
    assign m_err_now      = m_err_reg;
    assign m_integral_now = m_sum_reg;

endmodule
